// File: rtl/mpc_pkg.sv
// ----------------------------------------------------------------------------
// Midpoint circle package
// Item types, step descriptor, mode codes and decision constants shared by
// the front, step queue and point sequencer.
// ----------------------------------------------------------------------------
`default_nettype none

package mpc_pkg;

    localparam int COORD_BITS = 8;
    localparam int RADIUS_BITS = 7;
    localparam int OFFY_BITS = 9;
    localparam int DEC_BITS = 12;
    localparam int QUEUE_DEPTH = 2;
    localparam int POINTS_PER_STEP = 8;
    localparam int PT_BITS = $clog2(POINTS_PER_STEP);

    localparam logic [DEC_BITS-1:0] DEC_START = DEC_BITS'(3);
    localparam logic [DEC_BITS-1:0] DEC_DIAG = DEC_BITS'(10);
    localparam logic [DEC_BITS-1:0] DEC_AXIS = DEC_BITS'(6);

    localparam logic MODE_START = 1'b0;
    localparam logic MODE_NEXT = 1'b1;

    typedef logic [COORD_BITS-1:0] t_coord;

    typedef struct packed {
        logic                   mode;
        t_coord                 center_x;
        t_coord                 center_y;
        logic [RADIUS_BITS-1:0] radius;
    } t_in_item;

    typedef struct packed {
        t_coord pixel_x;
        t_coord pixel_y;
        logic   last_of_step;
        logic   circle_done;
    } t_out_item;

    typedef struct packed {
        t_coord cx;
        t_coord cy;
        t_coord ox;
        t_coord oy;
        logic   done;
    } t_step;

    typedef struct packed {
        logic  valid;
        t_step step;
    } t_step_req;

endpackage

`default_nettype wire

// File: rtl/mpc_front.sv
// ----------------------------------------------------------------------------
// Midpoint circle front
// Accepts items, classifies start / next / dropped, advances the octant
// offsets and decision value, and pushes one step descriptor per step.
// ----------------------------------------------------------------------------
`default_nettype none

module mpc_front (
    input  wire                 i_clk,
    input  wire                 i_rst_n,
    input  wire                 i_push,
    input  mpc_pkg::t_in_item   i_item,
    input  wire                 i_full,
    output mpc_pkg::t_step_req  o_req
);
    import mpc_pkg::*;

    t_coord                r_cx, n_cx;
    t_coord                r_cy, n_cy;
    t_coord                r_ox, n_ox;
    logic [OFFY_BITS-1:0]  r_oy, n_oy;
    logic [DEC_BITS-1:0]   r_dec, n_dec;
    logic                  r_active, n_active;

    logic                  accept;
    logic                  is_start;
    logic                  is_step;
    t_coord                ox_inc;
    logic [OFFY_BITS-1:0]  oy_dec;
    logic [DEC_BITS-1:0]   diff;
    logic [DEC_BITS-1:0]   dec_diag;
    logic [DEC_BITS-1:0]   dec_axis;
    logic                  done;

    assign accept   = i_push && !i_full;
    assign is_start = accept && (i_item.mode == MODE_START);
    assign is_step  = accept && (i_item.mode == MODE_NEXT) && r_active;

    always_comb begin
        ox_inc   = r_ox + t_coord'(1);
        oy_dec   = r_oy - OFFY_BITS'(1);
        diff     = DEC_BITS'(ox_inc) - {{(DEC_BITS - OFFY_BITS){oy_dec[OFFY_BITS-1]}}, oy_dec};
        dec_diag = r_dec + (diff << 2) + DEC_DIAG;
        dec_axis = r_dec + (DEC_BITS'(ox_inc) << 2) + DEC_AXIS;

        n_cx     = r_cx;
        n_cy     = r_cy;
        n_ox     = r_ox;
        n_oy     = r_oy;
        n_dec    = r_dec;
        n_active = r_active;
        done     = 1'b0;

        if (is_start) begin
            n_cx     = i_item.center_x;
            n_cy     = i_item.center_y;
            n_ox     = '0;
            n_oy     = OFFY_BITS'(i_item.radius);
            n_dec    = DEC_START - (DEC_BITS'(i_item.radius) << 1);
            n_active = 1'b1;
        end else if (is_step) begin
            n_ox = ox_inc;
            if ($signed(r_dec) > 0) begin
                n_oy  = oy_dec;
                n_dec = dec_diag;
            end else begin
                n_dec = dec_axis;
            end
            done = $signed({n_oy[OFFY_BITS-1], n_oy}) < $signed({2'b00, ox_inc});
            if (done) begin
                n_active = 1'b0;
            end
        end

        o_req.valid     = is_start || is_step;
        o_req.step.cx   = n_cx;
        o_req.step.cy   = n_cy;
        o_req.step.ox   = n_ox;
        o_req.step.oy   = n_oy[COORD_BITS-1:0];
        o_req.step.done = done;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cx     <= '0;
            r_cy     <= '0;
            r_ox     <= '0;
            r_oy     <= '0;
            r_dec    <= '0;
            r_active <= 1'b0;
        end else begin
            r_cx     <= n_cx;
            r_cy     <= n_cy;
            r_ox     <= n_ox;
            r_oy     <= n_oy;
            r_dec    <= n_dec;
            r_active <= n_active;
        end
    end

    a_done_idles: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (is_step && done) |=> !r_active)
        else $error("final step left the circle running");

endmodule

`default_nettype wire

// File: rtl/mpc_queue.sv
// ----------------------------------------------------------------------------
// Midpoint circle step queue
// Two-entry queue of step descriptors between front and point sequencer.
// ----------------------------------------------------------------------------
`default_nettype none

module mpc_queue (
    input  wire                 i_clk,
    input  wire                 i_rst_n,
    input  mpc_pkg::t_step_req  i_req,
    output logic                o_full,
    output logic                o_valid,
    output mpc_pkg::t_step      o_step,
    input  wire                 i_take
);
    import mpc_pkg::*;

    localparam int PTR_BITS = $clog2(QUEUE_DEPTH);
    localparam int CNT_BITS = $clog2(QUEUE_DEPTH + 1);

    t_step                 r_mem [QUEUE_DEPTH];
    logic [PTR_BITS-1:0]   r_wr, n_wr;
    logic [PTR_BITS-1:0]   r_rd, n_rd;
    logic [CNT_BITS-1:0]   r_count, n_count;
    logic                  do_push;
    logic                  do_pop;

    assign o_full  = (r_count == CNT_BITS'(QUEUE_DEPTH));
    assign o_valid = (r_count != '0);
    assign o_step  = r_mem[r_rd];
    assign do_push = i_req.valid;
    assign do_pop  = i_take && o_valid;

    always_comb begin
        n_wr    = do_push ? PTR_BITS'(r_wr + 1'b1) : r_wr;
        n_rd    = do_pop ? PTR_BITS'(r_rd + 1'b1) : r_rd;
        n_count = r_count + CNT_BITS'(do_push) - CNT_BITS'(do_pop);
    end

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wr] <= i_req.step;
        end
        if (!i_rst_n) begin
            r_wr    <= '0;
            r_rd    <= '0;
            r_count <= '0;
        end else begin
            r_wr    <= n_wr;
            r_rd    <= n_rd;
            r_count <= n_count;
        end
    end

    a_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(do_push && o_full))
        else $error("step pushed into full queue");

    a_no_underflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(i_take && !o_valid))
        else $error("step taken from empty queue");

endmodule

`default_nettype wire

// File: rtl/mpc_back.sv
// ----------------------------------------------------------------------------
// Midpoint circle point sequencer
// Expands each step descriptor into its eight symmetric pixels, one per
// cycle while the output is not stalled, through a registered output stage.
// ----------------------------------------------------------------------------
`default_nettype none

module mpc_back (
    input  wire                 i_clk,
    input  wire                 i_rst_n,
    input  wire                 i_valid,
    input  mpc_pkg::t_step      i_step,
    output logic                o_take,
    output logic                o_empty,
    output mpc_pkg::t_out_item  o_item,
    input  wire                 i_pop
);
    import mpc_pkg::*;

    localparam logic [PT_BITS-1:0] LAST_PT = PT_BITS'(POINTS_PER_STEP - 1);

    t_step                r_desc;
    logic                 r_busy;
    logic [PT_BITS-1:0]   r_k;
    logic                 r_valid;
    t_out_item            r_item;

    logic                 out_free;
    t_coord               ax;
    t_coord               ay;
    t_out_item            point;

    assign out_free = !r_valid || i_pop;
    assign o_take   = i_valid && (!r_busy || (out_free && (r_k == LAST_PT)));
    assign o_empty  = !r_valid;
    assign o_item   = r_item;

    always_comb begin
        ax = r_k[2] ? r_desc.oy : r_desc.ox;
        ay = r_k[2] ? r_desc.ox : r_desc.oy;
        point.pixel_x      = r_k[0] ? (r_desc.cx - ax) : (r_desc.cx + ax);
        point.pixel_y      = r_k[1] ? (r_desc.cy - ay) : (r_desc.cy + ay);
        point.last_of_step = (r_k == LAST_PT);
        point.circle_done  = r_desc.done;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy  <= 1'b0;
            r_k     <= '0;
            r_valid <= 1'b0;
        end else begin
            if (out_free) begin
                r_valid <= r_busy;
                if (r_busy) begin
                    r_item <= point;
                end
            end
            if (o_take) begin
                r_desc <= i_step;
                r_busy <= 1'b1;
                r_k    <= '0;
            end else if (out_free && r_busy) begin
                r_k <= r_k + 1'b1;
                if (r_k == LAST_PT) begin
                    r_busy <= 1'b0;
                end
            end
        end
    end

    a_hold_point: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_busy && !out_free && !o_take) |=> $stable(r_k))
        else $error("point index advanced while output stalled");

    a_take_at_end: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_take && r_busy) |-> (r_k == LAST_PT))
        else $error("new step loaded mid-sequence");

endmodule

`default_nettype wire

// File: rtl/midpoint_circle_point_generator.sv
// ----------------------------------------------------------------------------
// Midpoint circle point generator
// A start item loads centre and radius and yields the eight symmetric pixels
// of offset (0, r); each next item advances one octant step and yields eight
// more. The front takes one item per cycle while its two-entry step queue
// has room; the point sequencer sends one pixel per cycle while its output
// is not stalled. An accepted item reaches the output through the step
// queue, the sequencer's descriptor register and its output register. Next
// items while no circle runs are taken and produce nothing.
// ----------------------------------------------------------------------------
`default_nettype none

module midpoint_circle_point_generator (
    input  wire                 i_clk,
    input  wire                 i_rst_n,
    input  wire                 i_push,
    output logic                o_full,
    input  mpc_pkg::t_in_item   i_item,
    output logic                o_empty,
    input  wire                 i_pop,
    output mpc_pkg::t_out_item  o_item
);
    import mpc_pkg::*;

    t_step_req  req;
    logic       q_valid;
    t_step      q_step;
    logic       take;

    mpc_front u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (i_push),
        .i_item  (i_item),
        .i_full  (o_full),
        .o_req   (req)
    );

    mpc_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (req),
        .o_full  (o_full),
        .o_valid (q_valid),
        .o_step  (q_step),
        .i_take  (take)
    );

    mpc_back u_back (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (q_valid),
        .i_step  (q_step),
        .o_take  (take),
        .o_empty (o_empty),
        .o_item  (o_item),
        .i_pop   (i_pop)
    );

endmodule

`default_nettype wire
